@@ rtl/u16u8_pkg.sv @@
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types and constants shared by the UTF-16 key to UTF-8 byte transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

    // Input item: one UTF-16 code unit plus the entry-open flag.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        entry_open;
    } t_in;

    // Result item: one UTF-8 byte or a backspace event.
    typedef struct packed {
        logic       kind;
        logic [7:0] text_byte;
        logic       last;
    } t_out;

    localparam int MaxResults = 4;

    // Decoder result for one input item: byte count and the bytes in order.
    typedef struct packed {
        logic [2:0]                 count;
        t_out [MaxResults-1:0]      res;
    } t_dec;

    localparam logic KindText      = 1'b0;
    localparam logic KindBackspace = 1'b1;

    localparam logic [15:0] CuCr        = 16'h000D;
    localparam logic [15:0] CuLf        = 16'h000A;
    localparam logic [15:0] CuBackspace = 16'h0008;
    localparam logic [15:0] HighFirst   = 16'hD800;
    localparam logic [15:0] HighLast    = 16'hDBFF;
    localparam logic [15:0] LowFirst    = 16'hDC00;
    localparam logic [15:0] LowLast     = 16'hDFFF;
    localparam logic [20:0] SuppBase    = 21'h10000;
    localparam logic [20:0] CpDelete    = 21'h0007F;
    localparam logic [20:0] CpSpace     = 21'h00020;
    localparam logic [20:0] CpTwoByte   = 21'h00080;
    localparam logic [20:0] CpThreeByte = 21'h00800;
    localparam logic [7:0]  ByteNewline = 8'h0A;
    localparam logic [7:0]  LeadTwo     = 8'hC0;
    localparam logic [7:0]  LeadThree   = 8'hE0;
    localparam logic [7:0]  LeadFour    = 8'hF0;
    localparam logic [1:0]  ContTag     = 2'b10;

endpackage

`default_nettype wire

@@ rtl/u16u8_decode.sv @@
// ----------------------------------------------------------------------------
// u16u8_decode
// Turns one registered code unit into up to four result items and keeps the
// pending high surrogate, which advances only when the item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_decode import u16u8_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire t_in i_item,
    input  wire      i_take,
    output t_dec     o_dec
);

    logic [15:0] r_held;
    logic [15:0] n_held;
    logic [15:0] cu;
    logic [20:0] cp;
    logic [7:0]  b [MaxResults];
    logic [2:0]  n_bytes;
    logic        encode;

    assign cu = i_item.code_unit;

    always_comb begin
        n_held = r_held;
        encode = 1'b0;
        cp     = {5'd0, cu};
        o_dec  = '0;
        if (!i_item.entry_open) begin
            o_dec.count = 3'd0;
        end else if (cu == CuCr || cu == CuLf) begin
            o_dec.count            = 3'd1;
            o_dec.res[0].kind      = KindText;
            o_dec.res[0].text_byte = ByteNewline;
            o_dec.res[0].last      = 1'b1;
        end else if (cu == CuBackspace) begin
            o_dec.count            = 3'd1;
            o_dec.res[0].kind      = KindBackspace;
            o_dec.res[0].text_byte = 8'd0;
            o_dec.res[0].last      = 1'b1;
        end else if (cu inside {[HighFirst:HighLast]}) begin
            n_held = cu;
        end else if ((cu inside {[LowFirst:LowLast]}) && r_held == 16'd0) begin
            // drop an orphan low surrogate
            n_held = r_held;
        end else begin
            if (cu inside {[LowFirst:LowLast]}) begin
                cp = {1'b0, r_held[9:0], cu[9:0]} + SuppBase;
            end
            n_held = 16'd0;
            encode = !(cp < CpSpace || cp == CpDelete);
        end

        // UTF-8 byte layout by code point range
        if (cp < CpTwoByte) begin
            n_bytes = 3'd1;
            b[0] = cp[7:0];
            b[1] = 8'd0;
            b[2] = 8'd0;
            b[3] = 8'd0;
        end else if (cp < CpThreeByte) begin
            n_bytes = 3'd2;
            b[0] = LeadTwo | {3'd0, cp[10:6]};
            b[1] = {ContTag, cp[5:0]};
            b[2] = 8'd0;
            b[3] = 8'd0;
        end else if (cp < SuppBase) begin
            n_bytes = 3'd3;
            b[0] = LeadThree | {4'd0, cp[15:12]};
            b[1] = {ContTag, cp[11:6]};
            b[2] = {ContTag, cp[5:0]};
            b[3] = 8'd0;
        end else begin
            n_bytes = 3'd4;
            b[0] = LeadFour | {5'd0, cp[20:18]};
            b[1] = {ContTag, cp[17:12]};
            b[2] = {ContTag, cp[11:6]};
            b[3] = {ContTag, cp[5:0]};
        end

        if (encode) begin
            o_dec.count = n_bytes;
            for (int k = 0; k < MaxResults; k++) begin
                o_dec.res[k].kind      = KindText;
                o_dec.res[k].text_byte = b[k];
                o_dec.res[k].last      = (3'(k + 1) == n_bytes);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 16'd0;
        end else if (i_take) begin
            r_held <= n_held;
        end
    end

endmodule

`default_nettype wire

@@ rtl/u16u8_outbuf.sv @@
// ----------------------------------------------------------------------------
// u16u8_outbuf
// Holds the result items of one input item and shifts them out one per
// cycle while i_ready is high; the head entry is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_outbuf import u16u8_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_load,
    input  wire t_dec i_dec,
    input  wire       i_ready,
    output logic      o_valid,
    output t_out      o_data,
    output logic      o_free
);

    t_out [MaxResults-1:0] r_buf;
    t_out [MaxResults-1:0] n_buf;
    logic [2:0]            r_cnt;

    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_buf[0];
    // free when empty or when the final item leaves this cycle
    assign o_free  = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_ready);

    always_comb begin
        for (int k = 0; k < MaxResults - 1; k++) begin
            n_buf[k] = r_buf[k + 1];
        end
        n_buf[MaxResults-1] = r_buf[MaxResults-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_dec.count;
        end else if (o_valid && i_ready) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_dec.res;
        end else if (o_valid && i_ready) begin
            r_buf <= n_buf;
        end
    end

endmodule

`default_nettype wire

@@ rtl/utf16_key_to_utf8_bytes.sv @@
// ----------------------------------------------------------------------------
// utf16_key_to_utf8_bytes
// UTF-16 key code units in, UTF-8 bytes and backspace events out.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  input   | i_valid / o_ready  | i_data  (code_unit, entry_open)
//  output  | o_valid / i_ready  | o_data  (kind, text_byte, last)
//
//  An item enters the input register, is decoded from it combinationally
//  and is loaded into the output buffer once that is free. Results leave
//  one per cycle while i_ready is high; an item holds the buffer until its
//  last result leaves, and the next item can load as that result leaves.
//  Items that give no result leave the input register even while the
//  buffer is busy. Reset clears the held surrogate and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_key_to_utf8_bytes import u16u8_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_valid,
    output logic     o_ready,
    input  wire t_in i_data,
    output logic     o_valid,
    input  wire      i_ready,
    output t_out     o_data
);

    logic r_in_valid;
    t_in  r_in;
    t_dec dec;
    logic buf_free;
    logic s1_go;

    // drain the input register into the buffer, or drop it if it gives nothing
    assign s1_go   = r_in_valid && (buf_free || dec.count == 3'd0);
    assign o_ready = !r_in_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (s1_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_data;
        end
    end

    u16u8_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_in),
        .i_take  (s1_go),
        .o_dec   (dec)
    );

    u16u8_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_go && dec.count != 3'd0),
        .i_dec   (dec),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_data  (o_data),
        .o_free  (buf_free)
    );

endmodule

`default_nettype wire
